FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the core rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(expr), msg)

`endif

FILE: rtl/core/cmcc_pkg.sv
// shared types and constants of the chunk map cache controller
// no dependencies; used by cmcc_ctrl, cmcc_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package cmcc_pkg;

    localparam int OffsetW  = 32;
    localparam int CountW   = 16;
    localparam int StampW   = 32;
    localparam int SlotIdxW = 10;
    localparam int DataW    = 32;
    localparam int PaddrW   = 3;

    // register index codes (byte address bits above the word offset)
    localparam logic [PaddrW-3:0] RegChunkCount = 1'b0;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr_init;
        logic clr_step;
        logic item_load;
        logic map_read;
        logic res_oor;
        logic res_hit;
        logic scan_init;
        logic scan_step;
        logic unmap;
        logic install;
        logic out_load;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic map_hit;
        logic scan_last;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/cmcc_datapath.sv
// datapath: map and slot memories, clear and scan counters, victim search, result registers
// depends on cmcc_pkg; driven by cmcc_ctrl through cmcc_pkg::cmd_t
`timescale 1ns / 1ps
`default_nettype none

module cmcc_datapath #(
    parameter int CHUNK_BYTES = 2048,
    parameter int SLOT_COUNT  = 1024,
    parameter int MAP_DEPTH   = 32768
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [cmcc_pkg::OffsetW-1:0]      s_rom_offset,
    input  wire logic [cmcc_pkg::CountW-1:0]       rom_chunk_count,
    input  wire cmcc_pkg::cmd_t                    cmd,
    output cmcc_pkg::sts_t                         sts,
    output logic                                   m_valid_res,
    output logic [cmcc_pkg::SlotIdxW-1:0]          m_slot_index,
    output logic [cmcc_pkg::OffsetW-1:0]           m_chunk_start,
    output logic                                   m_fill_needed
);

    localparam int ChunkShift = $clog2(CHUNK_BYTES);
    localparam int ChunkW     = cmcc_pkg::OffsetW - ChunkShift;
    localparam int SlotW      = $clog2(SLOT_COUNT);
    localparam int MapW       = $clog2(MAP_DEPTH);
    localparam int ClrLen     = (MAP_DEPTH > SLOT_COUNT) ? MAP_DEPTH : SLOT_COUNT;
    localparam int ClrW       = $clog2(ClrLen);
    localparam int LimW       = ((MapW + 1) > cmcc_pkg::CountW) ? (MapW + 1) : cmcc_pkg::CountW;
    localparam int MapEntW    = 1 + SlotW;
    localparam int SlotEntW   = 1 + MapW + cmcc_pkg::StampW;

    logic [MapEntW-1:0]  map_mem  [MAP_DEPTH];
    logic [SlotEntW-1:0] slot_mem [SLOT_COUNT];

    logic [cmcc_pkg::OffsetW-1:0] offset_reg;
    logic [MapEntW-1:0]           map_q_reg;
    logic [SlotEntW-1:0]          slot_q_reg;

    logic [ClrW-1:0]  clr_cnt_reg,  clr_cnt_next;
    logic [SlotW-1:0] scan_cnt_reg, scan_cnt_next;
    logic             cmp_vld_reg;
    logic [SlotW-1:0] cmp_idx_reg;

    logic [cmcc_pkg::StampW-1:0] best_stamp_reg, best_stamp_next;
    logic [SlotW-1:0]            best_idx_reg,   best_idx_next;
    logic                        best_valid_reg, best_valid_next;
    logic [MapW-1:0]             best_chunk_reg, best_chunk_next;
    logic [cmcc_pkg::StampW-1:0] stamp_reg,      stamp_next;

    logic             res_valid_reg, res_valid_next;
    logic [SlotW-1:0] res_slot_reg,  res_slot_next;
    logic             res_fill_reg,  res_fill_next;

    logic [ChunkW-1:0] chunk;
    logic [MapW-1:0]   map_idx;
    logic [LimW-1:0]   count_ext, limit;
    logic              clr_in_map, clr_in_slot;

    logic               map_we;
    logic [MapW-1:0]    map_wa;
    logic [MapEntW-1:0] map_wd;
    logic                slot_we;
    logic [SlotW-1:0]    slot_wa;
    logic [SlotEntW-1:0] slot_wd;

    logic                        q_valid;
    logic [MapW-1:0]             q_chunk;
    logic [cmcc_pkg::StampW-1:0] q_stamp;
    logic                        take;

    assign chunk     = offset_reg[cmcc_pkg::OffsetW-1:ChunkShift];
    assign map_idx   = MapW'(chunk);
    assign count_ext = LimW'(rom_chunk_count);
    assign limit     = (count_ext > LimW'(MAP_DEPTH)) ? LimW'(MAP_DEPTH) : count_ext;

    assign clr_in_map  = {1'b0, clr_cnt_reg} < (ClrW + 1)'(MAP_DEPTH);
    assign clr_in_slot = {1'b0, clr_cnt_reg} < (ClrW + 1)'(SLOT_COUNT);

    assign sts.clr_last  = clr_cnt_reg == ClrW'(ClrLen - 1);
    assign sts.in_range  = 32'(chunk) < 32'(limit);
    assign sts.map_hit   = map_q_reg[MapEntW-1];
    assign sts.scan_last = scan_cnt_reg == SlotW'(SLOT_COUNT - 1);

    // map write port: clear, unmap of the victim's old chunk, install
    always_comb begin
        map_we = 1'b0;
        map_wa = map_idx;
        map_wd = '0;
        if (cmd.clr_step) begin
            map_we = clr_in_map;
            map_wa = MapW'(clr_cnt_reg);
        end else if (cmd.unmap) begin
            map_we = best_valid_reg;
            map_wa = best_chunk_reg;
        end else if (cmd.install) begin
            map_we = 1'b1;
            map_wd = {1'b1, best_idx_reg};
        end
    end

    // slot write port: clear or install
    always_comb begin
        slot_we = 1'b0;
        slot_wa = best_idx_reg;
        slot_wd = '0;
        if (cmd.clr_step) begin
            slot_we = clr_in_slot;
            slot_wa = SlotW'(clr_cnt_reg);
        end else if (cmd.install) begin
            slot_we = 1'b1;
            slot_wd = {1'b1, map_idx, stamp_reg + 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (cmd.map_read) begin
            map_q_reg <= map_mem[map_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (cmd.scan_step) begin
            slot_q_reg <= slot_mem[scan_cnt_reg];
        end
    end

    assign q_valid = slot_q_reg[SlotEntW-1];
    assign q_chunk = slot_q_reg[cmcc_pkg::StampW +: MapW];
    assign q_stamp = slot_q_reg[cmcc_pkg::StampW-1:0];
    assign take    = cmp_vld_reg && ((cmp_idx_reg == '0) || (q_stamp < best_stamp_reg));

    always_comb begin
        clr_cnt_next    = clr_cnt_reg;
        scan_cnt_next   = scan_cnt_reg;
        best_stamp_next = best_stamp_reg;
        best_idx_next   = best_idx_reg;
        best_valid_next = best_valid_reg;
        best_chunk_next = best_chunk_reg;
        stamp_next      = stamp_reg;
        res_valid_next  = res_valid_reg;
        res_slot_next   = res_slot_reg;
        res_fill_next   = res_fill_reg;

        if (cmd.clr_init) begin
            clr_cnt_next = '0;
        end else if (cmd.clr_step) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end

        if (cmd.scan_init) begin
            scan_cnt_next = '0;
        end else if (cmd.scan_step) begin
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end

        // strict less-than keeps the lowest index on equal stamps
        if (take) begin
            best_stamp_next = q_stamp;
            best_idx_next   = cmp_idx_reg;
            best_valid_next = q_valid;
            best_chunk_next = q_chunk;
        end

        if (cmd.res_oor) begin
            res_valid_next = 1'b0;
            res_slot_next  = '0;
            res_fill_next  = 1'b0;
        end else if (cmd.res_hit) begin
            res_valid_next = 1'b1;
            res_slot_next  = map_q_reg[SlotW-1:0];
            res_fill_next  = 1'b0;
        end else if (cmd.install) begin
            res_valid_next = 1'b1;
            res_slot_next  = best_idx_reg;
            res_fill_next  = 1'b1;
            stamp_next     = stamp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            cmp_vld_reg <= 1'b0;
            stamp_reg   <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            cmp_vld_reg <= cmd.scan_step;
            stamp_reg   <= stamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            offset_reg <= s_rom_offset;
        end
        scan_cnt_reg   <= scan_cnt_next;
        cmp_idx_reg    <= scan_cnt_reg;
        best_stamp_reg <= best_stamp_next;
        best_idx_reg   <= best_idx_next;
        best_valid_reg <= best_valid_next;
        best_chunk_reg <= best_chunk_next;
        res_valid_reg  <= res_valid_next;
        res_slot_reg   <= res_slot_next;
        res_fill_reg   <= res_fill_next;
        if (cmd.out_load) begin
            m_valid_res   <= res_valid_reg;
            m_slot_index  <= cmcc_pkg::SlotIdxW'(res_slot_reg);
            m_chunk_start <= res_valid_reg
                ? (offset_reg & ~cmcc_pkg::OffsetW'(CHUNK_BYTES - 1)) : '0;
            m_fill_needed <= res_fill_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cmcc_ctrl.sv
// controller state machine: sequences clear, lookup, victim scan and install
// depends on cmcc_pkg; drives cmcc_datapath through cmcc_pkg::cmd_t
`timescale 1ns / 1ps
`default_nettype none

module cmcc_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire logic            cfg_wr,
    input  wire cmcc_pkg::sts_t  sts,
    output cmcc_pkg::cmd_t       cmd
);

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_MAP_RD   = 9'b000000100,
        ST_MAP_CHK  = 9'b000001000,
        ST_SCAN     = 9'b000010000,
        ST_SCAN_END = 9'b000100000,
        ST_EVICT    = 9'b001000000,
        ST_INSTALL  = 9'b010000000,
        ST_RESP     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && !cfg_wr;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_MAP_RD;
                end
            end
            ST_MAP_RD: begin
                if (sts.in_range) begin
                    cmd.map_read = 1'b1;
                    state_next   = ST_MAP_CHK;
                end else begin
                    cmd.res_oor = 1'b1;
                    state_next  = ST_RESP;
                end
            end
            ST_MAP_CHK: begin
                if (sts.map_hit) begin
                    cmd.res_hit = 1'b1;
                    state_next  = ST_RESP;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_EVICT;
            end
            ST_EVICT: begin
                cmd.unmap  = 1'b1;
                state_next = ST_INSTALL;
            end
            ST_INSTALL: begin
                cmd.install = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        // register write restarts the clearing sweep
        if (cfg_wr) begin
            cmd          = '0;
            cmd.clr_init = 1'b1;
            state_next   = ST_CLEAR;
        end
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/chunk_map_cache_controller.sv
// top level of the chunk map cache controller: register port, controller and datapath
// depends on cmcc_pkg, cmcc_ctrl, cmcc_datapath and assert_macros.svh
//
// usage
// - register port: one register, rom_chunk_count at byte address 0 (16 bits used);
//   a write sets the chunk count and clears the map and slot tables, the stamp
//   counter keeps its value; pready is tied high, reads return the count
// - input channel s_*: one item carries a rom byte offset
// - result channel m_*: one item per input item, in order: in-range flag, slot,
//   chunk start offset and a fill request on a miss
// - out-of-range offsets (chunk not below min(count, MAP_DEPTH)) give an all-zero item
// sequencing
// - hit: the item is accepted, the map is read, the result register is loaded, then the output register
// - out-of-range: the range check fails and loads the result register without a map read
// - miss: a scan over all SLOT_COUNT slots, then unmap and install; the victim search
//   reads one slot stamp a cycle through the single read port of the slot memory
// - one item is worked on at a time; the next item is taken as soon as the
//   previous result sits in the output register
// reset and stalls
// - after reset and after every register write a clearing sweep over
//   max(MAP_DEPTH, SLOT_COUNT) entries (32768 by default) runs with s_ready low
// - a stalled receiver holds the output register; a finished item then waits
//   inside with s_ready low until the register frees
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module chunk_map_cache_controller #(
    parameter int CHUNK_BYTES = 2048,
    parameter int SLOT_COUNT  = 1024,
    parameter int MAP_DEPTH   = 32768
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cmcc_pkg::PaddrW-1:0]     paddr,
    input  wire logic [cmcc_pkg::DataW-1:0]      pwdata,
    output logic [cmcc_pkg::DataW-1:0]           prdata,
    output logic                                 pready,
    // input items
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [cmcc_pkg::OffsetW-1:0]    s_rom_offset,
    // result items
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_valid_res,
    output logic [cmcc_pkg::SlotIdxW-1:0]        m_slot_index,
    output logic [cmcc_pkg::OffsetW-1:0]         m_chunk_start,
    output logic                                 m_fill_needed
);

    logic [cmcc_pkg::CountW-1:0] count_reg, count_next;
    logic                        cfg_wr;
    logic                        sel_count;
    logic [3:0]                  map_port_users;
    cmcc_pkg::cmd_t              cmd;
    cmcc_pkg::sts_t              sts;

    // register decode ignores the byte offset within the word
    assign sel_count = paddr[cmcc_pkg::PaddrW-1:2] == cmcc_pkg::RegChunkCount;
    assign cfg_wr    = psel && penable && pwrite && pready && sel_count;
    assign pready    = 1'b1;
    assign prdata    = sel_count ? cmcc_pkg::DataW'(count_reg) : '0;

    assign count_next = cfg_wr ? pwdata[cmcc_pkg::CountW-1:0] : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    cmcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cfg_wr  (cfg_wr),
        .sts     (sts),
        .cmd     (cmd)
    );

    cmcc_datapath #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .SLOT_COUNT  (SLOT_COUNT),
        .MAP_DEPTH   (MAP_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_rom_offset    (s_rom_offset),
        .rom_chunk_count (count_reg),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid_res     (m_valid_res),
        .m_slot_index    (m_slot_index),
        .m_chunk_start   (m_chunk_start),
        .m_fill_needed   (m_fill_needed)
    );

    assign map_port_users = {cmd.clr_step, cmd.map_read, cmd.unmap, cmd.install};

    // only one item in flight at a time
    `ASSERT_CLK(a_one_item, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "busy but ready")
    // a register write always starts the clearing sweep
    `ASSERT_CLK(a_cfg_clear, aclk, aresetn, cfg_wr |=> !s_ready, "input open after register write")
    // the output register is never overwritten while a result still waits
    `ASSERT_CLK(a_out_free, aclk, aresetn, cmd.out_load |-> (!m_valid || m_ready), "result lost")
    // map memory port users are exclusive
    `ASSERT_NEVER(a_map_port, aclk, aresetn, !$onehot0(map_port_users), "map port conflict")

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// testbench for chunk_map_cache_controller: directed table then random offsets,
// every result checked against typed rows or an in-bench chunk map and fifo slot table
// depends on cmcc_pkg and the chunk_map_cache_controller rtl
`timescale 1ns / 1ps

module testbench;

    localparam int CHUNK_BYTES = 2048;
    localparam int SLOT_COUNT  = 1024;
    localparam int MAP_DEPTH   = 32768;

    // longest quiet spell: a full clearing sweep plus a miss scan, with margin
    localparam int QUIET_LIMIT = 4 * (MAP_DEPTH + SLOT_COUNT + 64);

    localparam logic [cmcc_pkg::PaddrW-1:0] COUNT_ADDR = {cmcc_pkg::RegChunkCount, 2'b00};

    // one result item, fields in port order
    typedef struct packed {
        logic                          valid_res;
        logic [cmcc_pkg::SlotIdxW-1:0] slot_index;
        logic [cmcc_pkg::OffsetW-1:0]  chunk_start;
        logic                          fill_needed;
    } lookup_t;

    localparam lookup_t NO_CHUNK = '0;

    // kinds of row in the directed table
    typedef enum logic [1:0] {
        OP_SET_COUNT,     // idle the block, then write rom_chunk_count
        OP_LOOKUP,        // send an offset, result from the predictor
        OP_LOOKUP_KNOWN   // send an offset, result typed into the row
    } op_t;

    typedef struct packed {
        op_t          kind;
        logic [31:0]  value;
        lookup_t      want;
    } plan_row_t;

    // idling modes of the two channels
    typedef enum int {
        PACE_STEADY,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH_GAPS
    } pace_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [cmcc_pkg::PaddrW-1:0]   paddr         = '0;
    logic [cmcc_pkg::DataW-1:0]    pwdata        = '0;
    logic [cmcc_pkg::DataW-1:0]    prdata;
    logic                          pready;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic [cmcc_pkg::OffsetW-1:0]  s_rom_offset  = '0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic                          m_valid_res;
    logic [cmcc_pkg::SlotIdxW-1:0] m_slot_index;
    logic [cmcc_pkg::OffsetW-1:0]  m_chunk_start;
    logic                          m_fill_needed;

    chunk_map_cache_controller #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .SLOT_COUNT  (SLOT_COUNT),
        .MAP_DEPTH   (MAP_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rom_offset  (s_rom_offset),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_valid_res   (m_valid_res),
        .m_slot_index  (m_slot_index),
        .m_chunk_start (m_chunk_start),
        .m_fill_needed (m_fill_needed)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------
    // predictor state: chunk map, per-slot table, stamp counter
    // ---------------------------------------------------------------
    logic [cmcc_pkg::CountW-1:0]   chunk_count;
    bit                            map_ok     [MAP_DEPTH];
    logic [cmcc_pkg::SlotIdxW-1:0] map_slot   [MAP_DEPTH];
    bit                            slot_ok    [SLOT_COUNT];
    logic [15:0]                   slot_chunk [SLOT_COUNT];
    logic [cmcc_pkg::StampW-1:0]   slot_stamp [SLOT_COUNT];
    logic [cmcc_pkg::StampW-1:0]   stamp_ctr;
    int unsigned                   fills_predicted;

    lookup_t     pending_lookups [$];   // results still owed by the block, oldest first
    int unsigned loaded_chunks [$];     // chunks filled since the last count write
    int unsigned error_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned quiet_cycles;

    // a count write empties both tables; the stamp counter carries on
    function automatic void wipe_cache_tables();
        for (int i = 0; i < MAP_DEPTH; i++) begin
            map_ok[i]   = 1'b0;
            map_slot[i] = '0;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_ok[i]    = 1'b0;
            slot_chunk[i] = '0;
            slot_stamp[i] = '0;
        end
        loaded_chunks.delete();
    endfunction

    // expected result for one offset, updating the tables on a miss
    function automatic lookup_t lookup_chunk(input logic [cmcc_pkg::OffsetW-1:0] off);
        lookup_t     res;
        int unsigned chunk;
        int unsigned usable;
        int unsigned slot;
        res    = NO_CHUNK;
        chunk  = off / CHUNK_BYTES;
        // counts past the map depth saturate there
        usable = (chunk_count > MAP_DEPTH) ? MAP_DEPTH : 32'(chunk_count);
        if (chunk >= usable)
            return res;
        if (map_ok[chunk]) begin
            slot = 32'(map_slot[chunk]);
        end else begin
            // oldest stamp wins, lowest index on ties; hits never restamp
            slot = 0;
            for (int i = 1; i < SLOT_COUNT; i++)
                if (slot_stamp[i] < slot_stamp[slot])
                    slot = i;
            if (slot_ok[slot])
                map_ok[slot_chunk[slot]] = 1'b0;
            stamp_ctr        = stamp_ctr + 1;
            slot_ok[slot]    = 1'b1;
            slot_chunk[slot] = 16'(chunk);
            slot_stamp[slot] = stamp_ctr;
            map_ok[chunk]    = 1'b1;
            map_slot[chunk]  = cmcc_pkg::SlotIdxW'(slot);
            res.fill_needed  = 1'b1;
            fills_predicted++;
        end
        res.valid_res   = 1'b1;
        res.slot_index  = cmcc_pkg::SlotIdxW'(slot);
        res.chunk_start = cmcc_pkg::OffsetW'(chunk * CHUNK_BYTES);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls and field-by-field compare
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        lookup_t got;
        lookup_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_valid_res, m_slot_index, m_chunk_start, m_fill_needed};
            if (pending_lookups.size() == 0) begin
                report_mismatch("unexpected item, chunk_start", got.chunk_start, '0);
            end else begin
                want = pending_lookups.pop_front();
                if (got.valid_res !== want.valid_res)
                    report_mismatch("valid_res", 32'(got.valid_res), 32'(want.valid_res));
                if (got.slot_index !== want.slot_index)
                    report_mismatch("slot_index", 32'(got.slot_index),
                                    32'(want.slot_index));
                if (got.chunk_start !== want.chunk_start)
                    report_mismatch("chunk_start", got.chunk_start, want.chunk_start);
                if (got.fill_needed !== want.fill_needed)
                    report_mismatch("fill_needed", 32'(got.fill_needed),
                                    32'(want.fill_needed));
            end
        end
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // watchdog: too long with no item moving on either channel ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // offer one offset, hold it until taken, then log what should come back
    task automatic send_offset(input logic [cmcc_pkg::OffsetW-1:0] off, input bit known,
                               input lookup_t known_res);
        lookup_t model_res;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_rom_offset <= off;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // predictor runs on every item so its tables track typed rows too
        model_res = lookup_chunk(off);
        pending_lookups.push_back(known ? known_res : model_res);
        if (model_res.fill_needed)
            loaded_chunks.push_back(off / CHUNK_BYTES);
    endtask

    task automatic wait_drained();
        while (pending_lookups.size() != 0)
            @(posedge aclk);
    endtask

    // count write while idle, then read it back; the write kicks off a clearing sweep
    task automatic set_chunk_count(input logic [cmcc_pkg::CountW-1:0] count);
        s_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= cmcc_pkg::DataW'(count);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // register taken at this edge
        chunk_count = count;
        wipe_cache_tables();
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== cmcc_pkg::DataW'(count))
            report_mismatch("rom_chunk_count readback", prdata, 32'(count));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random offset: mostly fresh in-range chunks, some past the span, with revisits of
    // resident and earlier loaded chunks so both hits and refills after eviction occur
    function automatic logic [cmcc_pkg::OffsetW-1:0] pick_offset(input int unsigned span);
        int unsigned roll;
        int unsigned slot;
        int unsigned low;
        roll = $urandom_range(99, 0);
        slot = $urandom_range(SLOT_COUNT - 1, 0);
        low  = $urandom_range(CHUNK_BYTES - 1, 0);
        if (roll < 4)
            return $urandom_range(32'hFFFF_FFFF, span * CHUNK_BYTES);
        if (roll < 10 && slot_ok[slot])
            return slot_chunk[slot] * CHUNK_BYTES + low;
        if (roll < 20 && loaded_chunks.size() != 0)
            return loaded_chunks[$urandom_range(loaded_chunks.size() - 1, 0)]
                   * CHUNK_BYTES + low;
        return $urandom_range(span - 1, 0) * CHUNK_BYTES + low;
    endfunction

    // random run in idling modes of 100 items each; the block drains fully
    // between modes, so the sender also sits waiting on an empty pipeline
    task automatic run_random(input int unsigned span, input int unsigned item_cap,
                              input int unsigned fill_goal);
        int unsigned sent;
        int unsigned fills_at_start;
        pace_t       pace;
        sent           = 0;
        fills_at_start = fills_predicted;
        pace           = pace_t'($urandom_range(3, 0));
        while (sent < item_cap && fills_predicted - fills_at_start < fill_goal) begin
            if (sent % 100 == 0) begin
                s_valid <= 1'b0;
                wait_drained();
                pace = pace_t'((pace + 1) % 4);
                case (pace)
                    PACE_STEADY: begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                    end
                    PACE_SEND_GAPS: begin
                        send_idle_pct  = 72;
                        recv_stall_pct = 0;
                    end
                    PACE_RECV_STALLS: begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 72;
                    end
                    default: begin
                        send_idle_pct  = 31;
                        recv_stall_pct = 31;
                    end
                endcase
                @(posedge aclk);
            end
            send_offset(pick_offset(span), 1'b0, NO_CHUNK);
            sent++;
        end
    endtask

    // directed rows: boundaries of the offset and of the chunk count,
    // count above the map depth, count of one and zero, hit after miss,
    // first-fill slot order and clearing on a count write
    plan_row_t directed_plan [23] = '{
        // count is zero after reset: nothing is in range
        '{OP_LOOKUP_KNOWN, 32'h0000_0000, NO_CHUNK},
        '{OP_LOOKUP_KNOWN, 32'hFFFF_FFFF, NO_CHUNK},
        // largest count: usable chunks stop at the map depth
        '{OP_SET_COUNT,    32'h0000_FFFF, NO_CHUNK},
        '{OP_LOOKUP_KNOWN, 32'h0000_0000, '{1'b1, 10'd0, 32'h0000_0000, 1'b1}},
        '{OP_LOOKUP_KNOWN, 32'h0000_07FF, '{1'b1, 10'd0, 32'h0000_0000, 1'b0}},
        '{OP_LOOKUP_KNOWN, 32'h0000_0800, '{1'b1, 10'd1, 32'h0000_0800, 1'b1}},
        '{OP_LOOKUP_KNOWN, 32'h03FF_FFFF, '{1'b1, 10'd2, 32'h03FF_F800, 1'b1}},
        '{OP_LOOKUP_KNOWN, 32'h0400_0000, NO_CHUNK},
        '{OP_LOOKUP_KNOWN, 32'hFFFF_F800, NO_CHUNK},
        '{OP_LOOKUP_KNOWN, 32'h0000_0801, '{1'b1, 10'd1, 32'h0000_0800, 1'b0}},
        '{OP_LOOKUP,       32'h03FF_F800, NO_CHUNK},
        // single-chunk rom; tables start empty again
        '{OP_SET_COUNT,    32'h0000_0001, NO_CHUNK},
        '{OP_LOOKUP_KNOWN, 32'h0000_0000, '{1'b1, 10'd0, 32'h0000_0000, 1'b1}},
        '{OP_LOOKUP_KNOWN, 32'h0000_0800, NO_CHUNK},
        '{OP_LOOKUP_KNOWN, 32'h0000_07FF, '{1'b1, 10'd0, 32'h0000_0000, 1'b0}},
        '{OP_SET_COUNT,    32'h0000_0000, NO_CHUNK},
        '{OP_LOOKUP_KNOWN, 32'h0000_0000, NO_CHUNK},
        // full map depth, kept for the eviction run that follows
        '{OP_SET_COUNT,    32'h0000_8000, NO_CHUNK},
        '{OP_LOOKUP_KNOWN, 32'h03FF_F800, '{1'b1, 10'd0, 32'h03FF_F800, 1'b1}},
        '{OP_LOOKUP,       32'h0400_0000, NO_CHUNK},
        '{OP_LOOKUP,       32'h0000_0000, NO_CHUNK},
        '{OP_LOOKUP,       32'h02AA_AAAA, NO_CHUNK},
        '{OP_LOOKUP,       32'h0155_5555, NO_CHUNK}
    };

    initial begin
        chunk_count     = '0;
        stamp_ctr       = '0;
        fills_predicted = 0;
        error_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        quiet_cycles    = 0;
        wipe_cache_tables();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            case (directed_plan[i].kind)
                OP_SET_COUNT:    set_chunk_count(directed_plan[i].value[cmcc_pkg::CountW-1:0]);
                OP_LOOKUP:       send_offset(directed_plan[i].value, 1'b0, NO_CHUNK);
                OP_LOOKUP_KNOWN: send_offset(directed_plan[i].value, 1'b1,
                                             directed_plan[i].want);
                default: ;
            endcase
        end

        // every slot filled, then the oldest recycled in fifo order
        run_random(MAP_DEPTH, 2000, 1060);

        // small rom: all chunks fit in the slots, so revisits hit; with out-of-range noise
        set_chunk_count(16'd40);
        run_random(40, 60, 32'hFFFF_FFFF);

        s_valid <= 1'b0;
        wait_drained();
        repeat (SLOT_COUNT + 16) @(posedge aclk);

        if (error_count == 0 && pending_lookups.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/cmcc_pkg.sv
rtl/core/cmcc_datapath.sv
rtl/core/cmcc_ctrl.sv
rtl/core/chunk_map_cache_controller.sv
verif/testbench.sv
